### hw/rtl/swa_pkg.sv
// Shared constants and types for the sliding window average core.
// Used by swa_window, swa_div_cell, the top level and the checker; no dependencies.
package swa_pkg;

	localparam int WINDOW_MAX   = 64;
	localparam int SAMPLE_BITS  = 16;
	localparam int FRAC_BITS    = 8;
	localparam int WSIZE_BITS   = 7;
	localparam int AVG_BITS     = 24;
	localparam int WSIZE_RESET  = 64;

	localparam int PTR_BITS  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CNT_BITS  = $clog2(WINDOW_MAX + 1);
	localparam int SUM_BITS  = SAMPLE_BITS + $clog2(WINDOW_MAX);
	localparam int DIVD_BITS = SUM_BITS + FRAC_BITS;
	localparam int DIV_STEPS = DIVD_BITS;

	// Window front end to divider chain.
	typedef struct packed {
		logic                        valid;
		logic signed [SUM_BITS-1:0]  sum;
		logic        [CNT_BITS-1:0]  held;
	} win_t;

	// One divider cell's state: partial remainder and the shared
	// dividend/quotient word (dividend bits leave at the top, quotient bits
	// enter at the bottom).
	typedef struct packed {
		logic                  valid;
		logic                  neg;
		logic [CNT_BITS-1:0]   divisor;
		logic [CNT_BITS-1:0]   rem;
		logic [DIVD_BITS-1:0]  word;
	} div_t;

endpackage

### hw/rtl/swa_window.sv
// Window front end: sample ring memory, oldest pointer, fill count, running sum.
// Depends on swa_pkg.
module swa_window (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [swa_pkg::WSIZE_BITS-1:0]        cfg_data,
	input  logic                                  in_valid,
	input  logic signed [swa_pkg::SAMPLE_BITS-1:0] sample,
	input  logic                                  adv,
	output swa_pkg::win_t                         win_o
);

	logic [swa_pkg::WSIZE_BITS-1:0]         wsize_q;
	logic [swa_pkg::PTR_BITS-1:0]           ptr_q;
	logic [swa_pkg::CNT_BITS-1:0]           fill_q;
	logic signed [swa_pkg::SUM_BITS-1:0]    sum_q;

	logic signed [swa_pkg::SAMPLE_BITS-1:0] ring_q [swa_pkg::WINDOW_MAX];
	logic signed [swa_pkg::SAMPLE_BITS-1:0] rd_q;
	logic signed [swa_pkg::SAMPLE_BITS-1:0] byp_data_q;
	logic                                   byp_q;

	logic                                   valid_s1;
	logic signed [swa_pkg::SUM_BITS-1:0]    sum_s1;
	logic [swa_pkg::CNT_BITS-1:0]           held_s1;

	logic                                   accept;
	logic [swa_pkg::CNT_BITS-1:0]           weff;
	logic                                   drop;
	logic signed [swa_pkg::SAMPLE_BITS-1:0] oldest;
	logic signed [swa_pkg::SUM_BITS-1:0]    sample_ext;
	logic signed [swa_pkg::SUM_BITS-1:0]    oldest_ext;
	logic signed [swa_pkg::SUM_BITS-1:0]    sum_nx;
	logic [swa_pkg::PTR_BITS-1:0]           ptr_inc;
	logic [swa_pkg::PTR_BITS-1:0]           ptr_nx;
	logic [swa_pkg::CNT_BITS-1:0]           fill_keep;
	logic [swa_pkg::CNT_BITS-1:0]           fill_nx;
	logic [swa_pkg::PTR_BITS:0]             wr_sum;
	logic [swa_pkg::PTR_BITS-1:0]           wr_addr;
	logic [swa_pkg::PTR_BITS-1:0]           rd_addr;

	assign accept = in_valid && adv;

	always_comb begin
		if (wsize_q == '0) begin
			weff = swa_pkg::CNT_BITS'(1);
		end else if (wsize_q > swa_pkg::WSIZE_BITS'(swa_pkg::WINDOW_MAX)) begin
			weff = swa_pkg::CNT_BITS'(swa_pkg::WINDOW_MAX);
		end else begin
			weff = swa_pkg::CNT_BITS'(wsize_q);
		end
	end

	assign drop   = (fill_q >= weff);
	assign oldest = byp_q ? byp_data_q : rd_q;

	assign sample_ext = {{(swa_pkg::SUM_BITS - swa_pkg::SAMPLE_BITS){sample[swa_pkg::SAMPLE_BITS-1]}},
		sample};
	assign oldest_ext = {{(swa_pkg::SUM_BITS - swa_pkg::SAMPLE_BITS){oldest[swa_pkg::SAMPLE_BITS-1]}},
		oldest};
	assign sum_nx = sum_q + sample_ext - (drop ? oldest_ext : '0);

	assign ptr_inc   = (ptr_q == swa_pkg::PTR_BITS'(swa_pkg::WINDOW_MAX - 1)) ? '0 : ptr_q + 1'b1;
	assign ptr_nx    = drop ? ptr_inc : ptr_q;
	assign fill_keep = drop ? fill_q - 1'b1 : fill_q;
	assign fill_nx   = fill_keep + 1'b1;

	assign wr_sum  = {1'b0, ptr_nx} + (swa_pkg::PTR_BITS+1)'(fill_keep);
	assign wr_addr = (wr_sum >= (swa_pkg::PTR_BITS+1)'(swa_pkg::WINDOW_MAX))
		? swa_pkg::PTR_BITS'(wr_sum - (swa_pkg::PTR_BITS+1)'(swa_pkg::WINDOW_MAX))
		: swa_pkg::PTR_BITS'(wr_sum);

	// Read always targets the next oldest entry, so its data is ready in the cycle after.
	assign rd_addr = cfg_we ? '0 : (accept ? ptr_nx : ptr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsize_q  <= swa_pkg::WSIZE_BITS'(swa_pkg::WSIZE_RESET);
			ptr_q    <= '0;
			fill_q   <= '0;
			sum_q    <= '0;
			byp_q    <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				wsize_q <= cfg_data;
				ptr_q   <= '0;
				fill_q  <= '0;
				sum_q   <= '0;
			end else if (accept) begin
				ptr_q  <= ptr_nx;
				fill_q <= fill_nx;
				sum_q  <= sum_nx;
			end
			byp_q <= accept && (wr_addr == rd_addr);
			if (adv) begin
				valid_s1 <= accept;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ring_q[wr_addr] <= sample;
		end
		rd_q       <= ring_q[rd_addr];
		byp_data_q <= sample;
		if (adv && accept) begin
			sum_s1  <= sum_nx;
			held_s1 <= fill_nx;
		end
	end

	assign win_o = '{valid: valid_s1, sum: sum_s1, held: held_s1};

endmodule

### hw/rtl/swa_div_cell.sv
// One restoring-division cell: produces one quotient bit per pass.
// Depends on swa_pkg.
module swa_div_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  swa_pkg::div_t d_i,
	output swa_pkg::div_t d_o
);

	logic                              valid_q;
	logic                              neg_q;
	logic [swa_pkg::CNT_BITS-1:0]      divisor_q;
	logic [swa_pkg::CNT_BITS-1:0]      rem_q;
	logic [swa_pkg::DIVD_BITS-1:0]     word_q;

	logic [swa_pkg::CNT_BITS:0]        trial;
	logic                              qbit;
	logic [swa_pkg::CNT_BITS-1:0]      rem_nx;

	always_comb begin
		trial  = {d_i.rem, d_i.word[swa_pkg::DIVD_BITS-1]};
		qbit   = (trial >= {1'b0, d_i.divisor});
		rem_nx = qbit ? swa_pkg::CNT_BITS'(trial - {1'b0, d_i.divisor})
			: swa_pkg::CNT_BITS'(trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= d_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_q     <= d_i.neg;
			divisor_q <= d_i.divisor;
			rem_q     <= rem_nx;
			word_q    <= {d_i.word[swa_pkg::DIVD_BITS-2:0], qbit};
		end
	end

	assign d_o = '{valid: valid_q, neg: neg_q, divisor: divisor_q, rem: rem_q, word: word_q};

endmodule

### hw/rtl/sliding_window_average_core.sv
// Top level of the sliding window average core.
// Depends on swa_pkg, swa_window and swa_div_cell.
//
// Takes one signed 16-bit sample per request and returns, for each, the mean
// of the last window_size samples (zero counts as one, above 64 as 64; fewer
// while the window fills) as signed fixed point with 8 fraction bits,
// truncated toward zero, together with the number of samples that mean covers.
// A new request is taken on every cycle while sample_stall is low: the front
// end updates the running sum from a ring memory whose oldest entry is
// prefetched (with a bypass for a same-cycle write), and the division runs down
// a chain of 30 identical cells, one quotient bit per cell, every cell passing
// its partial remainder to the next whenever the pipeline advances. A result
// passes the front end stage, which loads at the accepting edge, then the 30
// divider cells and one output register. The whole pipeline holds while a
// result waits under stall, and sample_stall is raised for exactly that time.
// Writing window_size empties the window; write it only while no request is
// in flight.
module sliding_window_average_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   window_size_wr_en,
	input  logic [swa_pkg::WSIZE_BITS-1:0]         window_size,
	input  logic                                   sample_valid,
	output logic                                   sample_stall,
	input  logic signed [swa_pkg::SAMPLE_BITS-1:0] sample,
	output logic                                   result_valid,
	input  logic                                   result_stall,
	output logic signed [swa_pkg::AVG_BITS-1:0]    average_q8,
	output logic [swa_pkg::CNT_BITS-1:0]           samples_held
);

	swa_pkg::win_t                       win;
	swa_pkg::div_t                       link [swa_pkg::DIV_STEPS+1];
	swa_pkg::div_t                       last;

	logic                                adv;
	logic [swa_pkg::SUM_BITS-1:0]        mag;
	logic [swa_pkg::DIVD_BITS-1:0]       quot_signed;

	logic                                out_valid_q;
	logic signed [swa_pkg::AVG_BITS-1:0] avg_q;
	logic [swa_pkg::CNT_BITS-1:0]        held_q;

	// Advance the whole pipeline unless a finished result is held by the sink.
	assign adv          = !out_valid_q || !result_stall;
	assign sample_stall = !adv;

	swa_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (window_size_wr_en),
		.cfg_data (window_size),
		.in_valid (sample_valid),
		.sample   (sample),
		.adv      (adv),
		.win_o    (win)
	);

	// Divide the magnitude and restore the sign at the end: this truncates
	// toward zero. Scale by the fraction bits on entry.
	assign mag = win.sum[swa_pkg::SUM_BITS-1] ? swa_pkg::SUM_BITS'(-win.sum)
		: swa_pkg::SUM_BITS'(win.sum);

	assign link[0] = '{
		valid:   win.valid,
		neg:     win.sum[swa_pkg::SUM_BITS-1],
		divisor: win.held,
		rem:     '0,
		word:    swa_pkg::DIVD_BITS'(mag) << swa_pkg::FRAC_BITS
	};

	for (genvar i = 0; i < swa_pkg::DIV_STEPS; i++) begin : g_cell
		swa_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.d_i    (link[i]),
			.d_o    (link[i+1])
		);
	end

	assign last        = link[swa_pkg::DIV_STEPS];
	assign quot_signed = last.neg ? -last.word : last.word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= last.valid;
		end
	end

	// Hold the payload while stalled; load only with a live result.
	always_ff @(posedge clk) begin
		if (adv && last.valid) begin
			avg_q  <= swa_pkg::AVG_BITS'(quot_signed);
			held_q <= last.divisor;
		end
	end

	assign result_valid = out_valid_q;
	assign average_q8   = avg_q;
	assign samples_held = held_q;

endmodule

### hw/rtl/swa_checker.sv
// Port-level checker for the sliding window average core, with its bind.
// Depends on swa_pkg and sliding_window_average_core.
module swa_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   sample_stall,
	input logic                                   result_valid,
	input logic                                   result_stall,
	input logic signed [swa_pkg::AVG_BITS-1:0]    average_q8,
	input logic [swa_pkg::CNT_BITS-1:0]           samples_held
);

	// Held result stays offered.
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	// Held result keeps its payload.
	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(average_q8) && $stable(samples_held))
		else $error("result payload changed while stalled");

	// Input stalls only behind a waiting result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> result_valid && result_stall)
		else $error("sample_stall raised with no result waiting");

	// Count covers at least one sample and never more than the store.
	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (samples_held != '0) &&
			(samples_held <= swa_pkg::CNT_BITS'(swa_pkg::WINDOW_MAX)))
		else $error("samples_held out of range");

	// Mean never exceeds the largest sample times the scale.
	a_avg_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(!average_q8[23] && (average_q8[22:8] == 15'h7fff) &&
			(average_q8[7:0] != 8'h00)))
		else $error("average_q8 above sample range");

endmodule

bind sliding_window_average_core swa_checker u_swa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_stall (sample_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.average_q8   (average_q8),
	.samples_held (samples_held)
);

### sim/sliding_window_average_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sliding_window_average_core: random bursts of samples, stalls.
// Depends on swa_pkg and the core RTL only; predicts every result in a small scoreboard class.
module sliding_window_average_core_tb;

	// Kinds of sample stream fed in a phase.
	typedef enum int {FEED_MIXED, FEED_FLOOR, FEED_CEILING} feed_t;

	// One predicted result: mean in Q8 and the number of samples it covers.
	typedef struct {
		logic signed [swa_pkg::AVG_BITS-1:0] mean;
		logic        [swa_pkg::CNT_BITS-1:0] held;
	} mean_t;

	// Tracks the window contents and holds the means still owed by the core.
	class moving_mean_tracker;
		logic signed [swa_pkg::SAMPLE_BITS-1:0] ring [swa_pkg::WINDOW_MAX];
		int unsigned head;
		int unsigned held;
		int unsigned span;
		longint      sum;
		mean_t       mean_due [$];
		int unsigned faults;

		function new();
			head = 0;
			held = 0;
			sum = 0;
			span = swa_pkg::WSIZE_RESET;
			faults = 0;
		endfunction

		// A window write empties the window; zero means one, oversize means full depth.
		function void restart_window(logic [swa_pkg::WSIZE_BITS-1:0] w);
			if (w == 0) begin
				span = 1;
			end else if (w > swa_pkg::WINDOW_MAX) begin
				span = swa_pkg::WINDOW_MAX;
			end else begin
				span = w;
			end
			head = 0;
			held = 0;
			sum = 0;
		endfunction

		function void take_sample(logic signed [swa_pkg::SAMPLE_BITS-1:0] s);
			mean_t  m;
			longint q;
			if (held >= span && held > 0) begin
				sum -= ring[head];
				head = (head + 1) % swa_pkg::WINDOW_MAX;
				held--;
			end
			ring[(head + held) % swa_pkg::WINDOW_MAX] = s;
			held++;
			sum += s;
			// Signed division truncates toward zero, as the core must.
			q = (sum * (longint'(1) << swa_pkg::FRAC_BITS)) / longint'(held);
			m.mean = q[swa_pkg::AVG_BITS-1:0];
			m.held = held[swa_pkg::CNT_BITS-1:0];
			mean_due.push_back(m);
		endfunction

		function void match_result(logic signed [swa_pkg::AVG_BITS-1:0] mean,
			logic [swa_pkg::CNT_BITS-1:0] cnt);
			mean_t m;
			if (mean_due.size() == 0) begin
				$display("%0t: result with none outstanding: average_q8 %0d samples_held %0d",
					$time, mean, cnt);
				faults++;
				return;
			end
			m = mean_due.pop_front();
			if (mean !== m.mean) begin
				$display("%0t: average_q8 expected %0d actual %0d", $time, m.mean, mean);
				faults++;
			end
			if (cnt !== m.held) begin
				$display("%0t: samples_held expected %0d actual %0d", $time, m.held, cnt);
				faults++;
			end
		endfunction

		function int pending();
			return mean_due.size();
		endfunction
	endclass

	logic                                   clk = 1'b0;
	logic                                   arst_n = 1'b0;
	logic                                   window_size_wr_en = 1'b0;
	logic [swa_pkg::WSIZE_BITS-1:0]         window_size = '0;
	logic                                   sample_valid = 1'b0;
	logic                                   sample_stall;
	logic signed [swa_pkg::SAMPLE_BITS-1:0] sample = '0;
	logic                                   result_valid;
	logic                                   result_stall = 1'b0;
	logic signed [swa_pkg::AVG_BITS-1:0]    average_q8;
	logic [swa_pkg::CNT_BITS-1:0]           samples_held;

	moving_mean_tracker tracker = new();

	// Receiver stall pattern: a level held for a random stretch, then redrawn.
	int stall_level = 0;
	int stall_left = 0;

	sliding_window_average_core u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.window_size_wr_en (window_size_wr_en),
		.window_size       (window_size),
		.sample_valid      (sample_valid),
		.sample_stall      (sample_stall),
		.sample            (sample),
		.result_valid      (result_valid),
		.result_stall      (result_stall),
		.average_q8        (average_q8),
		.samples_held      (samples_held)
	);

	always #5 clk = ~clk;

	// Check every result taken at this edge, then pick the stall for the next one.
	// Level 0 means no stalling at all, so quiet stretches occur as well.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			tracker.match_result(average_q8, samples_held);
		if (stall_left == 0) begin
			stall_level <= $urandom_range(0, 3);
			stall_left <= $urandom_range(16, 96);
		end else begin
			stall_left <= stall_left - 1;
		end
		result_stall <= (stall_level != 0) && ($urandom_range(0, 3) < stall_level);
	end

	// Mixed streams lean on the extremes so that sums reach both ends of their range.
	function automatic logic [swa_pkg::SAMPLE_BITS-1:0] pick_sample(feed_t feed);
		int r;
		r = $urandom_range(0, 9);
		case (feed)
			FEED_FLOOR: return {1'b1, {(swa_pkg::SAMPLE_BITS-1){1'b0}}};
			FEED_CEILING: return {1'b0, {(swa_pkg::SAMPLE_BITS-1){1'b1}}};
			default: begin
				if (r < 2)
					return {1'b1, {(swa_pkg::SAMPLE_BITS-1){1'b0}}};
				if (r < 4)
					return {1'b0, {(swa_pkg::SAMPLE_BITS-1){1'b1}}};
				if (r < 5)
					return swa_pkg::SAMPLE_BITS'($urandom_range(0, 3) - 2);
				return swa_pkg::SAMPLE_BITS'($urandom());
			end
		endcase
	endfunction

	// Present one request and hold it until the core takes it.
	task automatic send_one(input logic [swa_pkg::SAMPLE_BITS-1:0] val);
		sample_valid <= 1'b1;
		sample <= val;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		tracker.take_sample(val);
	endtask

	// Drain every outstanding result, then write the window length.
	// Called only with sample_valid already low.
	task automatic write_window(input logic [swa_pkg::WSIZE_BITS-1:0] w);
		while (tracker.pending() != 0)
			@(posedge clk);
		window_size_wr_en <= 1'b1;
		window_size <= w;
		@(posedge clk);
		window_size_wr_en <= 1'b0;
		tracker.restart_window(w);
	endtask

	// One setting of the window, then a stream sent in bursts with random gaps.
	task automatic run_phase(input logic [swa_pkg::WSIZE_BITS-1:0] w, input int count,
		input feed_t feed);
		int sent;
		int burst;
		write_window(w);
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 48);
			for (int k = 0; k < burst && sent < count; k++) begin
				send_one(pick_sample(feed));
				sent++;
			end
			if (sent < count && $urandom_range(0, 2) != 0) begin
				sample_valid <= 1'b0;
				repeat ($urandom_range(1, 7))
					@(posedge clk);
			end
		end
		sample_valid <= 1'b0;
	endtask

	// Window settings for the random part: extremes, both sides of full depth, saturation.
	logic [swa_pkg::WSIZE_BITS-1:0] plan_w [9] = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd64, 7'd65,
		7'd2, 7'd63, 7'd3};
	int    plan_n [9] = '{180, 100, 60, 80, 80, 150, 100, 150, 100};
	feed_t plan_f [9] = '{FEED_MIXED, FEED_MIXED, FEED_MIXED, FEED_FLOOR, FEED_CEILING,
		FEED_MIXED, FEED_MIXED, FEED_MIXED, FEED_MIXED};

	initial begin
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset window length, full-scale samples and alternating bit patterns.
		send_one(16'h8000);
		send_one(16'h7fff);
		send_one(16'h0000);
		send_one(16'hffff);
		send_one(16'h0001);
		send_one(16'h5555);
		send_one(16'haaaa);
		send_one(16'h0002);
		sample_valid <= 1'b0;

		// Short window, written over a part-filled one: negative means truncate toward zero.
		write_window(7'd3);
		send_one(16'hffff);
		send_one(16'h0000);
		send_one(16'h0000);
		send_one(16'h0001);
		send_one(16'h0007);
		sample_valid <= 1'b0;

		// Zero length behaves as a window of one.
		write_window(7'd0);
		send_one(16'h8000);
		send_one(16'h7fff);
		send_one(16'hffff);
		sample_valid <= 1'b0;

		// Lengths above full depth saturate.
		write_window(7'd127);
		send_one(16'h8000);
		send_one(16'h8000);
		send_one(16'h0003);
		sample_valid <= 1'b0;

		write_window(7'd65);
		send_one(16'h7fff);
		send_one(16'hfffd);
		sample_valid <= 1'b0;

		// Random part: planned settings, then a few drawn at random.
		for (int i = 0; i < 9; i++)
			run_phase(plan_w[i], plan_n[i], plan_f[i]);
		repeat (2)
			run_phase(swa_pkg::WSIZE_BITS'($urandom_range(0, 127)), 100, FEED_MIXED);

		// Drain, then keep the clock running so that anything stray still shows up.
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (40)
			@(posedge clk);
		if (tracker.faults == 0 && tracker.pending() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#5000000;
		$display("Mismatches found");
		$finish;
	end

endmodule

### files.f
hw/rtl/swa_pkg.sv
hw/rtl/swa_window.sv
hw/rtl/swa_div_cell.sv
hw/rtl/sliding_window_average_core.sv
hw/rtl/swa_checker.sv
sim/sliding_window_average_core_tb.sv
